// File: sv/b64e_pkg.sv
package b64e_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CharW   = 7;
    localparam int unsigned SextetW = 6;
    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [CharW-1:0] PadChar = 7'h3d;

    // Number of alphabet characters in a group; the rest is padding.
    localparam logic [2:0] NChars2 = 3'd2;
    localparam logic [2:0] NChars3 = 3'd3;
    localparam logic [2:0] NChars4 = 3'd4;

    typedef struct packed {
        logic [ByteW-1:0] b0;
        logic [ByteW-1:0] b1;
        logic [ByteW-1:0] b2;
        logic [2:0]       nchars;
        logic             fin;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] s);
        logic [CharW-1:0] ch;
        if (s < 6'd26) begin
            ch = 7'h41 + {1'b0, s};
        end else if (s < 6'd52) begin
            ch = 7'h61 + {1'b0, s - 6'd26};
        end else if (s < 6'd62) begin
            ch = 7'h30 + {1'b0, s - 6'd52};
        end else if (s == 6'd62) begin
            ch = 7'h2b;
        end else begin
            ch = 7'h2f;
        end
        return ch;
    endfunction

endpackage

// File: sv/b64e_front.sv
module b64e_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_fin,
    input  b64e_pkg::t_q_status   i_q_status,
    output logic                  o_ready,
    output logic                  o_push,
    output b64e_pkg::t_group      o_group
);
    import b64e_pkg::*;

    logic [ByteW-1:0] r_b0, n_b0;
    logic [ByteW-1:0] r_b1, n_b1;
    logic [1:0]       r_cnt, n_cnt;
    logic             w_take;

    assign o_ready = !i_q_status.full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_group = '{b0: r_b0, b1: r_b1, b2: i_byte, nchars: NChars4, fin: i_fin};
        if (w_take) begin
            // A count of three cannot arise; it is handled like two.
            if (r_cnt[1]) begin
                o_push = 1'b1;
                n_b0   = '0;
                n_b1   = '0;
                n_cnt  = '0;
            end else if (i_fin) begin
                o_push = 1'b1;
                if (r_cnt == 2'd0) begin
                    o_group = '{b0: i_byte, b1: '0, b2: '0, nchars: NChars2, fin: 1'b1};
                end else begin
                    o_group = '{b0: r_b0, b1: i_byte, b2: '0, nchars: NChars3, fin: 1'b1};
                end
                n_b0  = '0;
                n_b1  = '0;
                n_cnt = '0;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_b0 = i_byte;
                end else begin
                    n_b1 = i_byte;
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0  <= '0;
            r_b1  <= '0;
            r_cnt <= '0;
        end else begin
            r_b0  <= n_b0;
            r_b1  <= n_b1;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/b64e_queue.sv
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QueueDepthDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_group     i_group,
    input  logic                 i_pop,
    output b64e_pkg::t_group     o_group,
    output b64e_pkg::t_q_status  o_status
);
    import b64e_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_group          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_wr, w_rd;

    assign o_status.full  = (r_count == FullCnt);
    assign o_status.empty = (r_count == '0);
    assign w_wr    = i_push && !o_status.full;
    assign w_rd    = i_pop && !o_status.empty;
    assign o_group = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/b64e_back.sv
module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64e_pkg::t_group     i_group,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [6:0]           o_char,
    output logic                 o_last
);
    import b64e_pkg::*;

    t_group             r_grp;
    logic               r_active;
    logic [1:0]         r_idx;
    logic               r_out_valid;
    logic [CharW-1:0]   r_out_char;
    logic               r_out_last;
    logic               w_advance;
    logic               w_group_done;
    logic [SextetW-1:0] w_sextet;
    logic [CharW-1:0]   w_char;

    assign w_advance    = r_active && (!r_out_valid || i_ready);
    assign w_group_done = w_advance && (r_idx == 2'd3);
    assign o_pop        = !i_q_empty && (!r_active || w_group_done);

    always_comb begin
        case (r_idx)
            2'd0:    w_sextet = r_grp.b0[7:2];
            2'd1:    w_sextet = {r_grp.b0[1:0], r_grp.b1[7:4]};
            2'd2:    w_sextet = {r_grp.b1[3:0], r_grp.b2[7:6]};
            default: w_sextet = r_grp.b2[5:0];
        endcase
        w_char = ({1'b0, r_idx} < r_grp.nchars) ? sextet_char(w_sextet) : PadChar;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (w_advance) begin
            r_out_char <= w_char;
            r_out_last <= r_grp.fin && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (w_group_done) begin
                r_active <= 1'b0;
            end
            if (w_advance) begin
                r_idx       <= r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

// File: sv/base64_stream_encoder.sv
// A byte that closes a group passes through the group queue, the back end's group register and
// the output register before its first character shows. The output side sends one character
// per cycle while the sink is ready and groups are waiting, four characters per three bytes;
// the character emitter in the back end sets that pace. Input bytes are taken every cycle while
// the group queue between front and back has room. Reset is synchronous and active low; it
// empties the pending group, the queue and the output register.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] out_char, [7] zero
    output logic       o_m_tlast    // end_of_message
);
    import b64e_pkg::*;

    t_group    w_push_group;
    t_group    w_head_group;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;
    logic [CharW-1:0] w_char;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_byte     (i_s_tdata),
        .i_fin      (i_s_tlast),
        .i_q_status (w_q_status),
        .o_ready    (o_s_tready),
        .o_push     (w_push),
        .o_group    (w_push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_group  (w_push_group),
        .i_pop    (w_pop),
        .o_group  (w_head_group),
        .o_status (w_q_status)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_group   (w_head_group),
        .i_q_empty (w_q_status.empty),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_char    (w_char),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

    // The front end never pushes a group into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("group pushed into a full queue");

    // The back end only pops a group that is there.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("group popped from an empty queue");

    // A final byte always closes a group.
    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |-> w_push)
        else $error("final byte did not produce a group");

    // A pushed group is never lost: the queue is not empty next cycle, or a pop came with it.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_status.empty || $past(w_pop))
        else $error("pushed group vanished from the queue");

endmodule
